[hdl/assert_macros.svh]
// Assertion macros used by the checker file ldr_checker.
// Expects signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define LDR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Check on every clock edge, reset included.
`define LDR_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

[hdl/ldr_pkg.sv]
// Package of the longest diagonal run unit: widths, defaults and shared types.
// No dependencies.
package ldr_pkg;

   localparam int LDR_MAX_SIDE   = 128;
   localparam int LDR_LEN_W      = 8;
   localparam int LDR_RESET_SIDE = 128;

   typedef struct packed {
      logic                 shift;
      logic [LDR_LEN_W-1:0] run;
   } ldr_shift_type;

endpackage

[hdl/ldr_channels.sv]
// Handshake channels of the longest diagonal run unit.
// Depends on ldr_pkg.
interface ldr_req_if import ldr_pkg::*; ();
   logic valid;
   logic ready;
   logic cell_bit;

   modport source (output valid, output cell_bit, input ready);
   modport sink   (input valid, input cell_bit, output ready);
endinterface

interface ldr_rsp_if import ldr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LDR_LEN_W-1:0] longest_run;

   modport source (output valid, output longest_run, input ready);
   modport sink   (input valid, input longest_run, output ready);
endinterface

[hdl/ldr_cell.sv]
// One stage of the run line: holds one column's run of the previous row.
// Depends on ldr_pkg.
module ldr_cell import ldr_pkg::*; (
   input  logic                 clock,
   input  ldr_shift_type        ctrl,
   input  logic                 insert,
   input  logic [LDR_LEN_W-1:0] next_run,
   output logic [LDR_LEN_W-1:0] run
);

   logic [LDR_LEN_W-1:0] run_ff;
   logic [LDR_LEN_W-1:0] run_in;

   assign run_in = insert ? ctrl.run : next_run;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         run_ff <= run_in;
      end
   end

   assign run = run_ff;

endmodule

[hdl/ldr_line.sv]
// Chain of run cells forming a delay line whose length is the matrix side.
// Depends on ldr_pkg and ldr_cell.
module ldr_line import ldr_pkg::*; #(
   parameter int Depth = LDR_MAX_SIDE,
   localparam int IdxW = $clog2(Depth)
) (
   input  logic                 clock,
   input  ldr_shift_type        ctrl,
   input  logic [IdxW-1:0]      last_idx,
   output logic [LDR_LEN_W-1:0] head_run
);

   logic [LDR_LEN_W-1:0] runs [Depth];

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic [LDR_LEN_W-1:0] from_right;
      logic                 insert;

      if (i == Depth - 1) begin : g_tail
         assign from_right = ctrl.run;
      end else begin : g_body
         assign from_right = runs[i+1];
      end

      assign insert = (last_idx == IdxW'(i));

      ldr_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .insert   (insert),
         .next_run (from_right),
         .run      (runs[i])
      );
   end

   assign head_run = runs[0];

endmodule

[hdl/longest_diagonal_ones_run_unit.sv]
// Top level of the longest diagonal run unit.
// Depends on ldr_pkg, ldr_channels, ldr_line and ldr_cell.
//
//   channel   direction   payload              transfer
//   req_ch    in          cell_bit             valid && ready
//   rsp_ch    out         longest_run          valid && ready
//   csr       in          wr_data (side)       wr_en
//
// One cell per cycle; the run line is a chain of side cells that advances once
// per transfer, so each cell meets its column of the previous row without a
// memory port. The registered result leaves in the cycle after the last cell of
// a matrix. A pending result stalls only the last cell of the next matrix.
// Reset (synchronous) sets the side to 128 and restarts the matrix; the run
// line holds no reset value since row zero rewrites it.
module longest_diagonal_ones_run_unit import ldr_pkg::*; #(
   parameter int MAX_SIDE = LDR_MAX_SIDE
) (
   input  logic                 clock,
   input  logic                 reset,
   ldr_req_if.sink              req_ch,
   ldr_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [LDR_LEN_W-1:0] csr_wr_data
);

   localparam int IdxW  = $clog2(MAX_SIDE);
   localparam int SideW = ($clog2(MAX_SIDE + 1) > LDR_LEN_W) ?
                          $clog2(MAX_SIDE + 1) : LDR_LEN_W;

   logic [IdxW-1:0]      last_idx_ff, last_idx_in;
   logic [IdxW-1:0]      col_ff, col_in;
   logic [IdxW-1:0]      row_ff, row_in;
   logic [LDR_LEN_W-1:0] upleft_ff, upleft_in;
   logic [LDR_LEN_W-1:0] best_ff, best_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LDR_LEN_W-1:0] rsp_run_ff, rsp_run_in;

   logic [SideW-1:0]     side_clamp;
   logic [SideW-1:0]     reset_clamp;
   logic [LDR_LEN_W-1:0] head_run;
   logic [LDR_LEN_W-1:0] above;
   logic [LDR_LEN_W-1:0] diag;
   logic [LDR_LEN_W-1:0] run;
   logic [LDR_LEN_W-1:0] best_now;
   logic                 col_last;
   logic                 mat_last;
   logic                 take;
   ldr_shift_type        line_ctrl;

   always_comb begin
      side_clamp = SideW'(csr_wr_data);
      if (side_clamp == '0) begin
         side_clamp = SideW'(1);
      end
      if (side_clamp > SideW'(MAX_SIDE)) begin
         side_clamp = SideW'(MAX_SIDE);
      end
      reset_clamp = (LDR_RESET_SIDE > MAX_SIDE) ? SideW'(MAX_SIDE) : SideW'(LDR_RESET_SIDE);
   end

   assign col_last = (col_ff == last_idx_ff);
   assign mat_last = col_last && (row_ff == last_idx_ff);

   assign req_ch.ready = !(mat_last && rsp_valid_ff && !rsp_ch.ready);
   assign take         = req_ch.valid && req_ch.ready;

   assign above    = (row_ff != '0) ? head_run : '0;
   assign diag     = ((row_ff != '0) && (col_ff != '0)) ? upleft_ff : '0;
   assign run      = req_ch.cell_bit ? diag + LDR_LEN_W'(1) : '0;
   assign best_now = (run > best_ff) ? run : best_ff;

   assign line_ctrl.shift = take;
   assign line_ctrl.run   = run;

   ldr_line #(.Depth(MAX_SIDE)) u_line (
      .clock    (clock),
      .ctrl     (line_ctrl),
      .last_idx (last_idx_ff),
      .head_run (head_run)
   );

   always_comb begin
      last_idx_in  = last_idx_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      upleft_in    = upleft_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_run_in   = rsp_run_ff;
      if (csr_wr_en) begin
         last_idx_in = IdxW'(side_clamp - SideW'(1));
         col_in      = '0;
         row_in      = '0;
         upleft_in   = '0;
         best_in     = '0;
      end else if (take) begin
         best_in   = best_now;
         upleft_in = above;
         if (!col_last) begin
            col_in = col_ff + IdxW'(1);
         end else begin
            col_in    = '0;
            upleft_in = '0;
            if (!mat_last) begin
               row_in = row_ff + IdxW'(1);
            end else begin
               row_in       = '0;
               best_in      = '0;
               rsp_valid_in = 1'b1;
               rsp_run_in   = best_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff  <= IdxW'(reset_clamp - SideW'(1));
         col_ff       <= '0;
         row_ff       <= '0;
         upleft_ff    <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_idx_ff  <= last_idx_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         upleft_ff    <= upleft_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_run_ff <= rsp_run_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.longest_run = rsp_run_ff;

endmodule

[hdl/ldr_checker.sv]
// Port-level checks of the longest diagonal run unit, bound to the top level.
// Depends on assert_macros.svh and ldr_pkg.
`include "assert_macros.svh"

module ldr_checker import ldr_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [LDR_LEN_W-1:0] rsp_longest_run
);

   `LDR_ASSERT_ALWAYS(a_reset_no_rsp, reset |=> !rsp_valid)
   `LDR_ASSERT(a_stall_only_on_full, !req_ready |-> (rsp_valid && !rsp_ready))
   `LDR_ASSERT(a_rsp_valid_hold, (rsp_valid && !rsp_ready) |=> rsp_valid)
   `LDR_ASSERT(a_rsp_data_hold, (rsp_valid && !rsp_ready) |=> $stable(rsp_longest_run))

endmodule

bind longest_diagonal_ones_run_unit ldr_checker u_ldr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_longest_run (rsp_ch.longest_run)
);

[bench/longest_diagonal_ones_run_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the longest diagonal run unit: follows side writes and cell
// transfers, predicts the longest run of each matrix and checks every result.
// Depends on ldr_pkg.
module longest_diagonal_ones_run_checker import ldr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_cell_bit,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [LDR_LEN_W-1:0] rsp_longest_run,
   input  logic                 csr_wr_en,
   input  logic [LDR_LEN_W-1:0] csr_wr_data,
   output int                   failures,
   output int                   runs_pending,
   output int                   runs_checked
);

   localparam int IdxW = $clog2(LDR_MAX_SIDE);

   logic [LDR_LEN_W-1:0] side_setting;
   logic [LDR_LEN_W-1:0] prev_row_runs [LDR_MAX_SIDE];
   logic [LDR_LEN_W-1:0] upleft_run;
   logic [LDR_LEN_W-1:0] best_run;
   logic [LDR_LEN_W-1:0] col_pos;
   logic [LDR_LEN_W-1:0] row_pos;
   logic [LDR_LEN_W-1:0] longest_q [$];

   function automatic logic [LDR_LEN_W-1:0] usable_side();
      if (side_setting == '0) return LDR_LEN_W'(1);
      if (side_setting > LDR_LEN_W'(LDR_MAX_SIDE)) return LDR_LEN_W'(LDR_MAX_SIDE);
      return side_setting;
   endfunction

   function automatic void restart_matrix();
      upleft_run = '0;
      best_run   = '0;
      col_pos    = '0;
      row_pos    = '0;
   endfunction

   // Returns 1 when the cell closes the matrix; longest then holds the result.
   function automatic bit take_cell(input logic cell_val,
                                    output logic [LDR_LEN_W-1:0] longest);
      logic [LDR_LEN_W-1:0] side;
      logic [LDR_LEN_W-1:0] col;
      logic [LDR_LEN_W-1:0] above;
      logic [LDR_LEN_W-1:0] diag;
      logic [LDR_LEN_W:0]   run;
      side    = usable_side();
      col     = (col_pos >= side) ? side - LDR_LEN_W'(1) : col_pos;
      above   = (row_pos != '0) ? prev_row_runs[col[IdxW-1:0]] : '0;
      diag    = (row_pos != '0 && col != '0) ? upleft_run : '0;
      run     = cell_val ? {1'b0, diag} + (LDR_LEN_W+1)'(1) : '0;
      longest = '0;
      if (run > (LDR_LEN_W+1)'(255)) run = (LDR_LEN_W+1)'(255);
      prev_row_runs[col[IdxW-1:0]] = run[LDR_LEN_W-1:0];
      upleft_run = above;
      if (run[LDR_LEN_W-1:0] > best_run) best_run = run[LDR_LEN_W-1:0];
      if (col + LDR_LEN_W'(1) < side) begin
         col_pos = col + LDR_LEN_W'(1);
         return 0;
      end
      col_pos    = '0;
      upleft_run = '0;
      if (row_pos + LDR_LEN_W'(1) < side) begin
         row_pos = row_pos + LDR_LEN_W'(1);
         return 0;
      end
      longest = best_run;
      restart_matrix();
      return 1;
   endfunction

   always @(posedge clock) begin
      logic [LDR_LEN_W-1:0] longest;
      logic [LDR_LEN_W-1:0] want;
      if (reset) begin
         side_setting = LDR_LEN_W'(LDR_RESET_SIDE);
         restart_matrix();
         foreach (prev_row_runs[i]) prev_row_runs[i] = '0;
         longest_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (longest_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d",
                        $time, rsp_longest_run);
               failures <= failures + 1;
            end else begin
               want = longest_q.pop_front();
               if (rsp_longest_run !== want) begin
                  $display("%0t: longest_run mismatch, expected %0d, actual %0d",
                           $time, want, rsp_longest_run);
                  failures <= failures + 1;
               end
               runs_checked <= runs_checked + 1;
            end
         end
         if (csr_wr_en) begin
            side_setting = csr_wr_data;
            restart_matrix();
         end
         if (req_valid && req_ready) begin
            if (take_cell(req_cell_bit, longest)) longest_q.push_back(longest);
         end
      end
      runs_pending <= longest_q.size();
   end

endmodule

[bench/longest_diagonal_ones_run_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the longest diagonal run unit: drives cells, side writes
// and result back-pressure, and gives the verdict.
// Depends on ldr_pkg, ldr_channels, the unit and longest_diagonal_ones_run_checker.
module longest_diagonal_ones_run_unit_tb;
   import ldr_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_CELLS = 900;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_wr_en   = 1'b0;
   logic [LDR_LEN_W-1:0] csr_wr_data = '0;

   int failures;
   int runs_pending;
   int runs_checked;
   int burst_left  = 0;
   int cells_sent  = 0;
   int side_writes = 0;
   int idle_cycles = 0;
   bit hold_request = 1'b0;

   ldr_req_if req_ch ();
   ldr_rsp_if rsp_ch ();

   longest_diagonal_ones_run_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   longest_diagonal_ones_run_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_cell_bit    (req_ch.cell_bit),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_longest_run (rsp_ch.longest_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .failures        (failures),
      .runs_pending    (runs_pending),
      .runs_checked    (runs_checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stalls, plus a long hold when asked.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   task automatic send_bit(input logic b);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cell_bit <= b;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      cells_sent++;
   endtask

   task automatic send_pattern(input logic [31:0] bits, input int n);
      for (int i = n - 1; i >= 0; i--) send_bit(bits[i]);
   endtask

   task automatic send_cells(input int ones_pct, input int count);
      for (int i = 0; i < count; i++) send_bit($urandom_range(1, 100) <= ones_pct);
   endtask

   // Drain all results and let the block settle before a side write.
   task automatic write_side(input logic [LDR_LEN_W-1:0] v);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (runs_pending != 0);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      side_writes++;
   endtask

   // Hold off results with side 1 so the pending result backs up the input.
   task automatic squeeze(input int count);
      write_side(LDR_LEN_W'(1));
      hold_request = 1'b1;
      send_cells(50, count);
   endtask

   initial begin
      int random_cells;
      int side_eff;
      int count;
      int pick;
      int ones_pct;
      bit squeezed;
      random_cells = 0;
      side_eff     = 1;
      squeezed     = 1'b0;
      req_ch.valid    <= 1'b0;
      req_ch.cell_bit <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // partial matrix at the reset side, dropped by the next write
      send_pattern(32'b10110, 5);
      write_side(LDR_LEN_W'(1));
      send_pattern(32'b10, 2);
      write_side(LDR_LEN_W'(0));
      send_pattern(32'b1, 1);
      write_side(LDR_LEN_W'(2));
      send_pattern(32'b1001_0110, 8);
      write_side(LDR_LEN_W'(3));
      send_pattern(32'b100_010_001, 9);

      squeeze(24);
      // partial matrices at the largest side, past the first row wrap
      write_side(LDR_LEN_W'(128));
      send_cells(100, 200);
      write_side(LDR_LEN_W'(255));
      send_cells(90, 200);
      write_side(LDR_LEN_W'(1));

      while (random_cells < RANDOM_CELLS) begin
         if (!squeezed && random_cells > RANDOM_CELLS / 2) begin
            squeeze(20);
            squeezed = 1'b1;
            side_eff = 1;
         end
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               write_side(LDR_LEN_W'(0));
               side_eff = 1;
            end else begin
               side_eff = (pick < 70) ? $urandom_range(1, 6) :
                          (pick < 95) ? $urandom_range(7, 16) : $urandom_range(17, 30);
               write_side(side_eff[LDR_LEN_W-1:0]);
            end
         end
         case ($urandom_range(0, 4))
            0: ones_pct = 0;
            1: ones_pct = 30;
            2: ones_pct = 50;
            3: ones_pct = 80;
            default: ones_pct = 100;
         endcase
         count = side_eff * side_eff;
         if (count > 1 && $urandom_range(0, 7) == 0) begin
            // broken matrix: stop early and force a fresh side
            count = $urandom_range(1, count - 1);
            send_cells(ones_pct, count);
            write_side(side_eff[LDR_LEN_W-1:0]);
         end else begin
            send_cells(ones_pct, count);
         end
         random_cells += count;
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (runs_pending != 0);
      repeat (10) @(posedge clock);
      $display("Sent %0d cells over %0d side writes, %0d matrix results checked.",
               cells_sent, side_writes, runs_checked);
      $display("Sides 0 through 255 incl. saturation, abandoned matrices, long stalls.");
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/ldr_pkg.sv
hdl/ldr_channels.sv
hdl/ldr_cell.sv
hdl/ldr_line.sv
hdl/longest_diagonal_ones_run_unit.sv
hdl/ldr_checker.sv
bench/longest_diagonal_ones_run_checker.sv
bench/longest_diagonal_ones_run_unit_tb.sv
